// ----- design/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the buddy block allocator
// Table entry layout, status codes and the size rounding function.
// ----------------------------------------------------------------------------
`default_nettype none
package bba_pkg;

  localparam int PoolUnits  = 256;
  localparam int AddrBits   = 8;
  localparam int OwnerBits  = 8;
  localparam int OrderBits  = 4;
  localparam int SizeBits   = 9;
  localparam int ReqBits    = 9;
  localparam logic [OrderBits-1:0] TopOrder = 4'd8;

  localparam logic [1:0] StAllocated = 2'd0;
  localparam logic [1:0] StFreed     = 2'd1;
  localparam logic [1:0] StNoSpace   = 2'd2;
  localparam logic [1:0] StNotFound  = 2'd3;

  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;

  typedef struct packed {
    logic                 head;
    logic                 free_b;
    logic [OrderBits-1:0] order;
    logic [OwnerBits-1:0] owner;
  } entry_t;

  // Rounds a request up to the next power of two and returns its exponent.
  function automatic logic [OrderBits-1:0] size_order(input logic [ReqBits-1:0] req);
    logic [OrderBits-1:0] k;
    k = '0;
    for (int b = 0; b < 10; b++) begin
      if ((k == OrderBits'(b)) && ((11'(1) << b) < {2'b00, req})) begin
        k = OrderBits'(b + 1);
      end
    end
    return k;
  endfunction

endpackage
`default_nettype wire

// ----- design/bba_req_if.sv -----
// ----------------------------------------------------------------------------
// bba_req_if: request channel of the buddy block allocator
// Valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
`default_nettype none
interface bba_req_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [bba_pkg::OwnerBits-1:0] owner_id;
  logic [bba_pkg::ReqBits-1:0]   request_size;
  modport source (output valid, mode, owner_id, request_size, input ready);
  modport sink   (input valid, mode, owner_id, request_size, output ready);
endinterface
`default_nettype wire

// ----- design/bba_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bba_rsp_if: result channel of the buddy block allocator
// Valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
`default_nettype none
interface bba_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [bba_pkg::AddrBits-1:0] block_offset;
  logic [bba_pkg::SizeBits-1:0] block_size;
  modport source (output valid, status, block_offset, block_size, input ready);
  modport sink   (input valid, status, block_offset, block_size, output ready);
endinterface
`default_nettype wire

// ----- design/bba_table.sv -----
// ----------------------------------------------------------------------------
// bba_table: block table memory
// One write and one registered read per cycle; per-entry valid bits make
// unwritten entries read as their reset value.
// ----------------------------------------------------------------------------
`default_nettype none
module bba_table (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         we_i,
  input  wire logic [bba_pkg::AddrBits-1:0] waddr_i,
  input  wire bba_pkg::entry_t              wdata_i,
  input  wire logic [bba_pkg::AddrBits-1:0] raddr_i,
  output bba_pkg::entry_t                   rdata_o
);

  bba_pkg::entry_t                   mem_q [bba_pkg::PoolUnits];
  logic [bba_pkg::PoolUnits-1:0]     vld_q;
  bba_pkg::entry_t                   rd_q;
  logic                              rd_vld_q;
  logic [bba_pkg::AddrBits-1:0]      raddr_q;
  bba_pkg::entry_t                   rst_val;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q    <= mem_q[raddr_i];
    raddr_q <= raddr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[raddr_i];
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
    end
  end

  // After reset the whole pool is one free block of top order at entry 0.
  always_comb begin
    rst_val = '0;
    if (raddr_q == '0) begin
      rst_val.head   = 1'b1;
      rst_val.free_b = 1'b1;
      rst_val.order  = bba_pkg::TopOrder;
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : rst_val;

endmodule
`default_nettype wire

// ----- design/buddy_block_allocator_core.sv -----
// ----------------------------------------------------------------------------
// buddy_block_allocator_core: buddy allocator over 256 granules
// A sequencer walks the block table through one memory port per cycle.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req_i (mode, owner_id, request_size) and one
// result per request leaves on rsp_o (status, block_offset, block_size).
// A request is taken only while the block is idle and no result waits.
// An allocate scans block heads in address order, reading and then
// evaluating each visited entry; it then splits the found block one order
// at a time and finally claims it. A free scans the same way and then
// merges with its buddy (read, evaluate, write) step by step until the
// buddy is not a free block of the same order, or the block has reached
// the top order or the pool edge.
// The result is held in an output register until the receiver takes it;
// while it waits, no new request is accepted.
// Reset (rst_ni, asynchronous, active low) makes the pool one free block
// at offset 0 through per-entry valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module buddy_block_allocator_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bba_req_if.sink   req_i,
  bba_rsp_if.source rsp_o
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SCAN_RD  = 7'b0000010,
    S_SCAN_EV  = 7'b0000100,
    S_SPLIT    = 7'b0001000,
    S_MERGE_RD = 7'b0010000,
    S_MERGE_EV = 7'b0100000,
    S_MERGE_WR = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic                                  mode_q, mode_d;
  logic [bba_pkg::OwnerBits-1:0]         owner_q, owner_d;
  logic [bba_pkg::OrderBits-1:0]         k_q, k_d;
  logic [bba_pkg::AddrBits+1:0]          idx_q, idx_d;
  logic [bba_pkg::OrderBits-1:0]         ord_q, ord_d;
  logic [bba_pkg::OrderBits-1:0]         first_q, first_d;
  logic [bba_pkg::AddrBits-1:0]          off_q, off_d;
  logic                                  ovld_q, ovld_d;
  logic [1:0]                            ost_q, ost_d;
  logic [bba_pkg::AddrBits-1:0]          ooff_q, ooff_d;
  logic [bba_pkg::SizeBits-1:0]          osz_q, osz_d;

  logic                                  we;
  logic [bba_pkg::AddrBits-1:0]          waddr, raddr;
  bba_pkg::entry_t                       wdata, ent;
  logic [bba_pkg::SizeBits-1:0]          msz, bud;
  logic [bba_pkg::AddrBits+1:0]          bud_end;
  logic [bba_pkg::AddrBits-1:0]          lo, hi;
  logic                                  in_xfer;

  bba_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (ent)
  );

  assign req_i.ready = (state_q == S_IDLE) && !ovld_q;
  assign in_xfer     = req_i.valid && req_i.ready;

  // Buddy of the block being merged and the lower/upper of the pair.
  assign msz     = bba_pkg::SizeBits'(1) << ord_q;
  assign bud     = {1'b0, off_q} ^ msz;
  assign bud_end = {1'b0, bud} + {1'b0, msz};
  assign lo      = (off_q < bud[bba_pkg::AddrBits-1:0]) ? off_q : bud[bba_pkg::AddrBits-1:0];
  assign hi      = (off_q < bud[bba_pkg::AddrBits-1:0]) ? bud[bba_pkg::AddrBits-1:0] : off_q;

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    owner_d = owner_q;
    k_d     = k_q;
    idx_d   = idx_q;
    ord_d   = ord_q;
    first_d = first_q;
    off_d   = off_q;
    ovld_d  = ovld_q;
    ost_d   = ost_q;
    ooff_d  = ooff_q;
    osz_d   = osz_q;
    we      = 1'b0;
    waddr   = idx_q[bba_pkg::AddrBits-1:0];
    wdata   = '0;
    raddr   = idx_q[bba_pkg::AddrBits-1:0];

    if (ovld_q && rsp_o.ready) begin
      ovld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          mode_d  = req_i.mode;
          owner_d = req_i.owner_id;
          k_d     = bba_pkg::size_order(req_i.request_size);
          idx_d   = '0;
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (idx_q >= (bba_pkg::AddrBits+2)'(bba_pkg::PoolUnits)) begin
          ovld_d  = 1'b1;
          ost_d   = (mode_q == bba_pkg::ModeAlloc) ? bba_pkg::StNoSpace : bba_pkg::StNotFound;
          ooff_d  = '0;
          osz_d   = '0;
          state_d = S_IDLE;
        end else begin
          state_d = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        if (!ent.head) begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SCAN_RD;
        end else if ((mode_q == bba_pkg::ModeAlloc) && ent.free_b && (ent.order >= k_q)) begin
          ord_d   = ent.order;
          state_d = S_SPLIT;
        end else if ((mode_q == bba_pkg::ModeFree) && !ent.free_b && (ent.owner == owner_q)) begin
          we           = 1'b1;
          wdata        = ent;
          wdata.free_b = 1'b1;
          wdata.owner  = '0;
          ord_d        = ent.order;
          first_d      = ent.order;
          off_d        = idx_q[bba_pkg::AddrBits-1:0];
          state_d      = S_MERGE_RD;
        end else if (ent.order > bba_pkg::TopOrder) begin
          idx_d   = (bba_pkg::AddrBits+2)'(bba_pkg::PoolUnits);
          state_d = S_SCAN_RD;
        end else begin
          idx_d   = idx_q + ((bba_pkg::AddrBits+2)'(1) << ent.order);
          state_d = S_SCAN_RD;
        end
      end
      S_SPLIT: begin
        we = 1'b1;
        if (ord_q > k_q) begin
          // Each split leaves the upper half as a new free block.
          waddr        = idx_q[bba_pkg::AddrBits-1:0]
                         + (bba_pkg::AddrBits'(1) << (ord_q - 1'b1));
          wdata.head   = 1'b1;
          wdata.free_b = 1'b1;
          wdata.order  = ord_q - 1'b1;
          ord_d        = ord_q - 1'b1;
        end else begin
          wdata.head   = 1'b1;
          wdata.free_b = 1'b0;
          wdata.order  = k_q;
          wdata.owner  = owner_q;
          ovld_d       = 1'b1;
          ost_d        = bba_pkg::StAllocated;
          ooff_d       = idx_q[bba_pkg::AddrBits-1:0];
          osz_d        = bba_pkg::SizeBits'(1) << k_q;
          state_d      = S_IDLE;
        end
      end
      S_MERGE_RD: begin
        raddr = bud[bba_pkg::AddrBits-1:0];
        if ((ord_q >= bba_pkg::TopOrder) ||
            (bud_end > (bba_pkg::AddrBits+2)'(bba_pkg::PoolUnits))) begin
          ovld_d  = 1'b1;
          ost_d   = bba_pkg::StFreed;
          ooff_d  = idx_q[bba_pkg::AddrBits-1:0];
          osz_d   = bba_pkg::SizeBits'(1) << first_q;
          state_d = S_IDLE;
        end else begin
          state_d = S_MERGE_EV;
        end
      end
      S_MERGE_EV: begin
        if (ent.head && ent.free_b && (ent.order == ord_q)) begin
          we      = 1'b1;
          waddr   = hi;
          wdata   = '0;
          state_d = S_MERGE_WR;
        end else begin
          ovld_d  = 1'b1;
          ost_d   = bba_pkg::StFreed;
          ooff_d  = idx_q[bba_pkg::AddrBits-1:0];
          osz_d   = bba_pkg::SizeBits'(1) << first_q;
          state_d = S_IDLE;
        end
      end
      S_MERGE_WR: begin
        we           = 1'b1;
        waddr        = lo;
        wdata.head   = 1'b1;
        wdata.free_b = 1'b1;
        wdata.order  = ord_q + 1'b1;
        off_d        = lo;
        ord_d        = ord_q + 1'b1;
        state_d      = S_MERGE_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    owner_q <= owner_d;
    k_q     <= k_d;
    idx_q   <= idx_d;
    ord_q   <= ord_d;
    first_q <= first_d;
    off_q   <= off_d;
    ost_q   <= ost_d;
    ooff_q  <= ooff_d;
    osz_q   <= osz_d;
  end

  assign rsp_o.valid        = ovld_q;
  assign rsp_o.status       = ost_q;
  assign rsp_o.block_offset = ooff_q;
  assign rsp_o.block_size   = osz_q;

`ifndef SYNTHESIS
  // An accepted request always starts a scan.
  a_start_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_SCAN_RD))
    else $error("accepted request did not start a scan");

  // A waiting result is only shown while the sequencer is idle.
  a_rsp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q |-> (state_q == S_IDLE))
    else $error("result valid while sequencer busy");

  // Failed requests report an empty block.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && ((ost_q == bba_pkg::StNoSpace) || (ost_q == bba_pkg::StNotFound)))
      |-> ((osz_q == '0) && (ooff_q == '0)))
    else $error("failed request with nonzero block");
`endif

endmodule
`default_nettype wire
